FILE: rtl/core/echo_comb_allpass_delay_macros.svh
// ----------------------------------------------------------------------------
// echo_comb_allpass_delay_macros.svh
// assertion macros used by the delay-line effect checker
// ----------------------------------------------------------------------------
`ifndef ECHO_COMB_ALLPASS_DELAY_MACROS_SVH
`define ECHO_COMB_ALLPASS_DELAY_MACROS_SVH

// same-cycle implication, clocked on clk, quiet while arst_n is low
`define ECAD_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, quiet while arst_n is low
`define ECAD_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/ecad_pkg.sv
// ----------------------------------------------------------------------------
// ecad_pkg
// shared constants, register codes and helpers of the delay-line effect
// ----------------------------------------------------------------------------
package ecad_pkg;

	localparam int DEF_HISTORY_DEPTH = 4096;
	localparam int DEF_OUTPUT_DEPTH  = 4096;
	localparam int DEF_SAMPLE_BITS   = 16;

	localparam int DELAY_W     = 12;
	localparam int GAIN_W      = 16;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 2;
	localparam int FRAC_BITS   = 15;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_MODE  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DELAY = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN  = 2'd2;

	// effect modes, the unused code behaves as feed-forward
	localparam logic [1:0] MODE_FEEDFWD  = 2'd0;
	localparam logic [1:0] MODE_FEEDBACK = 2'd1;
	localparam logic [1:0] MODE_ALLPASS  = 2'd2;

	typedef logic [DELAY_W-1:0] delay_t;
	typedef logic signed [GAIN_W-1:0] gain_t;

	localparam delay_t DELAY_RESET = 12'd1;
	localparam gain_t  GAIN_RESET  = 16'sd16384;

	// delay reduced modulo a ring depth, restoring subtraction over the
	// few quotient bits a 12-bit delay can have against a depth of 16 or more
	function automatic delay_t delay_mod(input delay_t d, input int depth);
		logic [31:0] v;
		logic [31:0] step;
		v = 32'(d);
		for (int k = 7; k >= 0; k--) begin
			step = 32'(depth) << k;
			if ((step <= 32'((2 ** DELAY_W) - 1)) && (v >= step)) begin
				v = v - step;
			end
		end
		return delay_t'(v);
	endfunction

endpackage

FILE: rtl/core/ecad_ram.sv
// ----------------------------------------------------------------------------
// ecad_ram
// simple dual-port history memory, one write and one registered read
// ----------------------------------------------------------------------------
module ecad_ram import ecad_pkg::*; #(
	parameter int DEPTH  = DEF_HISTORY_DEPTH,
	parameter int DATA_W = DEF_SAMPLE_BITS
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/ecad_mix.sv
// ----------------------------------------------------------------------------
// ecad_mix
// one gain multiply-add in Q.15, truncation toward zero and saturation
// ----------------------------------------------------------------------------
module ecad_mix import ecad_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic [1:0]                    mode,
	input  gain_t                         gain,
	input  logic signed [SAMPLE_BITS-1:0] x,
	input  logic signed [SAMPLE_BITS-1:0] xd,
	input  logic signed [SAMPLE_BITS-1:0] yd,
	output logic signed [SAMPLE_BITS-1:0] y
);

	localparam int DIFF_W = SAMPLE_BITS + 1;
	localparam int PROD_W = GAIN_W + DIFF_W;
	localparam int ACC_W  = PROD_W + 1;
	localparam int QUO_W  = ACC_W - FRAC_BITS;
	localparam longint SAT_HI_L = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
	localparam logic signed [QUO_W-1:0] SAT_HI = QUO_W'(SAT_HI_L);
	localparam logic signed [QUO_W-1:0] SAT_LO = QUO_W'(-SAT_HI_L - 1);

	logic signed [DIFF_W-1:0] base;
	logic signed [DIFF_W-1:0] mul_in;
	logic signed [PROD_W-1:0] prod;
	logic signed [ACC_W-1:0]  acc;
	logic signed [QUO_W-1:0]  quo_floor;
	logic signed [QUO_W-1:0]  quo;
	logic                     frac_nz;

	always_comb begin
		unique case (mode)
			MODE_FEEDBACK: begin
				base   = DIFF_W'(x);
				mul_in = DIFF_W'(yd);
			end
			MODE_ALLPASS: begin
				base   = DIFF_W'(xd);
				mul_in = DIFF_W'(x) - DIFF_W'(yd);
			end
			default: begin
				base   = DIFF_W'(x);
				mul_in = DIFF_W'(xd);
			end
		endcase
	end

	assign prod      = PROD_W'(gain) * PROD_W'(mul_in);
	assign acc       = (ACC_W'(base) <<< FRAC_BITS) + ACC_W'(prod);
	assign quo_floor = QUO_W'(acc >>> FRAC_BITS);
	assign frac_nz   = |acc[FRAC_BITS-1:0];
	// negative with a fraction: floor plus one gives truncation toward zero
	assign quo       = (acc[ACC_W-1] && frac_nz) ? quo_floor + QUO_W'(1) : quo_floor;

	always_comb begin
		if (quo > SAT_HI) begin
			y = SAT_HI[SAMPLE_BITS-1:0];
		end else if (quo < SAT_LO) begin
			y = SAT_LO[SAMPLE_BITS-1:0];
		end else begin
			y = quo[SAMPLE_BITS-1:0];
		end
	end

endmodule

FILE: rtl/core/echo_comb_allpass_delay.sv
// ----------------------------------------------------------------------------
// echo_comb_allpass_delay
// delay-line audio effect: feed-forward echo, feedback echo, allpass variant
// ----------------------------------------------------------------------------
// samples enter on the s_axis stream and leave on the m_axis stream, one
// result for every accepted sample, in order
// flow: an accepted sample and its history reads are registered in stage one,
// and the single gain multiply-add feeds the output register on m_axis; one
// sample per cycle is sustained while m_axis is not stalled, in a two-stage pipe
// the output register parts the two sides: while m_axis is stalled one more
// sample is taken into the first stage, then s_axis_tready drops
// cfg_wen writes effect_mode, delay_samples or gain_q15; write
// only while no sample is in flight, the delay is reduced modulo each ring
// depth when written
// reset: async, active low; both histories read as zero until written, which
// is tracked by the write pointers and a wrapped flag per ring, so there is
// no clearing pass and samples are taken right after reset
// ----------------------------------------------------------------------------
module echo_comb_allpass_delay import ecad_pkg::*; #(
	parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
	parameter int OUTPUT_DEPTH  = DEF_OUTPUT_DEPTH,
	parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write port
	input  logic                                 cfg_wen,
	input  logic [CFG_INDEX_W-1:0]               cfg_index,
	input  logic [CFG_DATA_W-1:0]                cfg_data,
	// input stream
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,  // sample_in
	// output stream
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_axis_tdata   // sample_out
);

	localparam int S       = SAMPLE_BITS;
	localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int HW      = $clog2(HISTORY_DEPTH);
	localparam int OW      = $clog2(OUTPUT_DEPTH);

	// per-transaction tap selection carried into stage one
	typedef struct packed {
		logic xd_ok;    // input tap holds a written sample
		logic xd_self;  // zero delay, input tap is the sample itself
		logic yd_ok;    // output tap holds a written result
		logic yd_fwd;   // output tap is the result leaving stage one now
	} tap_sel_t;

	// configuration registers
	logic [1:0]    mode_q;
	gain_t         gain_q;
	logic [HW-1:0] dd_in_q;
	logic [OW-1:0] dd_out_q;

	// pointers and fill tracking
	logic [HW-1:0] wp_q;
	logic          wrap_in_q;
	logic [OW-1:0] op_q;
	logic          wrap_out_q;

	// handshake
	logic adv;
	logic acc_in;
	logic mv;

	// stage one
	logic                 s1_valid_q;
	logic signed [S-1:0]  x_s1;
	logic [OW-1:0]        op_s1;
	tap_sel_t             sel_s1;

	// output register
	logic                 out_valid_q;
	logic [S-1:0]         out_data_q;

	// taps
	logic signed [S-1:0]  x_in;
	logic [HW-1:0]        rx;
	logic [OW-1:0]        ry;
	tap_sel_t             sel_d;
	logic [S-1:0]         xd_mem;
	logic [S-1:0]         yd_mem;
	logic signed [S-1:0]  xd_use;
	logic signed [S-1:0]  yd_use;
	logic signed [S-1:0]  y;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_FEEDFWD;
			gain_q   <= GAIN_RESET;
			dd_in_q  <= HW'(delay_mod(DELAY_RESET, HISTORY_DEPTH));
			dd_out_q <= OW'(delay_mod(DELAY_RESET, OUTPUT_DEPTH));
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_MODE: begin
					mode_q <= cfg_data[1:0];
				end
				REG_DELAY: begin
					// ring offsets kept already reduced per ring
					dd_in_q  <= HW'(delay_mod(cfg_data[DELAY_W-1:0], HISTORY_DEPTH));
					dd_out_q <= OW'(delay_mod(cfg_data[DELAY_W-1:0], OUTPUT_DEPTH));
				end
				REG_GAIN: begin
					gain_q <= gain_t'(cfg_data[GAIN_W-1:0]);
				end
				default: begin
					// index beyond the register list, ignored
				end
			endcase
		end
	end

	// ---------------- handshake ----------------
	// stage one moves on whenever the output register is free or being taken
	assign adv           = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !s1_valid_q || adv;
	assign acc_in        = s_axis_tvalid && s_axis_tready;
	assign mv            = s1_valid_q && adv;

	assign x_in = s_axis_tdata[S-1:0];

	// ---------------- tap addresses ----------------
	always_comb begin
		if (wp_q >= dd_in_q) begin
			rx = wp_q - dd_in_q;
		end else begin
			rx = HW'((HW+1)'(wp_q) + (HW+1)'(HISTORY_DEPTH) - (HW+1)'(dd_in_q));
		end
		if (op_q >= dd_out_q) begin
			ry = op_q - dd_out_q;
		end else begin
			ry = OW'((OW+1)'(op_q) + (OW+1)'(OUTPUT_DEPTH) - (OW+1)'(dd_out_q));
		end
	end

	// entries below the pointer are written; after a wrap all of them are
	assign sel_d.xd_ok   = wrap_in_q || (rx < wp_q);
	assign sel_d.xd_self = (dd_in_q == '0);
	assign sel_d.yd_ok   = wrap_out_q || (ry < op_q);
	// the result in stage one is written to its entry at this very edge
	assign sel_d.yd_fwd  = s1_valid_q && (ry == op_s1);

	// ---------------- pointers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q       <= '0;
			wrap_in_q  <= 1'b0;
			op_q       <= '0;
			wrap_out_q <= 1'b0;
		end else if (acc_in) begin
			if (wp_q == HW'(HISTORY_DEPTH - 1)) begin
				wp_q      <= '0;
				wrap_in_q <= 1'b1;
			end else begin
				wp_q <= wp_q + HW'(1);
			end
			if (op_q == OW'(OUTPUT_DEPTH - 1)) begin
				op_q       <= '0;
				wrap_out_q <= 1'b1;
			end else begin
				op_q <= op_q + OW'(1);
			end
		end
	end

	// ---------------- histories ----------------
	ecad_ram #(
		.DEPTH  (HISTORY_DEPTH),
		.DATA_W (S)
	) u_in_hist (
		.clk   (clk),
		.we    (acc_in),
		.waddr (wp_q),
		.wdata (x_in),
		.re    (acc_in),
		.raddr (rx),
		.rdata (xd_mem)
	);

	ecad_ram #(
		.DEPTH  (OUTPUT_DEPTH),
		.DATA_W (S)
	) u_out_hist (
		.clk   (clk),
		.we    (mv),
		.waddr (op_s1),
		.wdata (y),
		.re    (acc_in),
		.raddr (ry),
		.rdata (yd_mem)
	);

	// ---------------- stage one ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (acc_in) begin
			s1_valid_q <= 1'b1;
		end else if (adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			x_s1   <= x_in;
			op_s1  <= op_q;
			sel_s1 <= sel_d;
		end
	end

	// unwritten entries read as zero; a forwarded tap is the result that
	// left stage one together with this transaction's arrival
	assign xd_use = sel_s1.xd_self ? x_s1 : (sel_s1.xd_ok ? xd_mem : '0);
	assign yd_use = sel_s1.yd_fwd ? out_data_q : (sel_s1.yd_ok ? yd_mem : '0);

	ecad_mix #(
		.SAMPLE_BITS (S)
	) u_mix (
		.mode (mode_q),
		.gain (gain_q),
		.x    (x_s1),
		.xd   (xd_use),
		.yd   (yd_use),
		.y    (y)
	);

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mv) begin
			out_data_q <= y;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = TDATA_W'(out_data_q);

endmodule

FILE: rtl/core/ecad_checker.sv
// ----------------------------------------------------------------------------
// ecad_checker
// port-level checks of the delay-line effect, bound to the top level
// ----------------------------------------------------------------------------
`include "echo_comb_allpass_delay_macros.svh"

module ecad_checker import ecad_pkg::*; #(
	parameter int DATA_W = ((DEF_SAMPLE_BITS + 7) / 8) * 8
) (
	input logic              clk,
	input logic              arst_n,
	input logic              s_axis_tvalid,
	input logic              s_axis_tready,
	input logic              m_axis_tvalid,
	input logic              m_axis_tready,
	input logic [DATA_W-1:0] m_axis_tdata
);

	logic [1:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	// transactions taken in but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_acc && !out_acc) begin
			pend_q <= pend_q + 2'd1;
		end else if (out_acc && !in_acc) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	`ECAD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed or dropped")
	`ECAD_ASSERT_SAME(a_ready_flow, m_axis_tready, s_axis_tready, "input stalled while output is taken")
	`ECAD_ASSERT_SAME(a_pend_max, 1'b1, pend_q <= 2'd2, "more than two transactions in flight")
	`ECAD_ASSERT_SAME(a_no_invent, pend_q == 2'd0, !m_axis_tvalid, "result shown with no transaction pending")

endmodule

bind echo_comb_allpass_delay ecad_checker #(
	.DATA_W ($bits(m_axis_tdata))
) u_ecad_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
